### rtl/igbt_pkg.sv
// igbt_pkg: shared constants for the greedy iou box tracker
// no dependencies
`timescale 1ns / 1ps
package igbt_pkg;
  localparam int MaxTracks     = 16;
  localparam int MaxDetections = 16;
  localparam int CoordBits     = 12;
  localparam int IdBits        = 16;
  localparam int CntBits       = 8;
  localparam int ThrBits       = 16;
  localparam int CfgIdxBits    = 2;

  localparam logic [CfgIdxBits-1:0] CFG_MISS_LIMIT   = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_CONFIRM_HITS = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_MIN_IOU      = 2'd2;

  localparam logic [CntBits-1:0] MissLimitReset   = 8'd30;
  localparam logic [CntBits-1:0] ConfirmHitsReset = 8'd3;
  localparam logic [ThrBits-1:0] MinIouReset      = 16'd19661;

  localparam logic CMD_DET = 1'b0;
  localparam logic CMD_EOF = 1'b1;
endpackage

### rtl/igbt_iou_unit.sv
// igbt_iou_unit: shared overlap / union unit, two register stages
// depends on igbt_pkg
`timescale 1ns / 1ps
module igbt_iou_unit import igbt_pkg::*; #(
  parameter int COORD_BITS = CoordBits
) (
  input  logic                      clk,
  input  logic [COORD_BITS-1:0]     a_x0, a_y0, a_x1, a_y1,
  input  logic [COORD_BITS-1:0]     b_x0, b_y0, b_x1, b_y1,
  output logic [2*COORD_BITS-1:0]   inter,
  output logic [2*COORD_BITS+1:0]   uni
);
  localparam int W = COORD_BITS;
  logic [W-1:0] ar, ab, br, bb, x0, y0, x1, y1;
  logic [W-1:0] iw_r, ih_r, aw_r, ah_r, bw_r, bh_r;
  logic         ov_r;
  logic [2*W-1:0] ia, aa, ba;
  logic [2*W+1:0] u;

  always_comb begin
    ar = (a_x1 > a_x0) ? a_x1 : a_x0;
    ab = (a_y1 > a_y0) ? a_y1 : a_y0;
    br = (b_x1 > b_x0) ? b_x1 : b_x0;
    bb = (b_y1 > b_y0) ? b_y1 : b_y0;
    x0 = (a_x0 > b_x0) ? a_x0 : b_x0;
    y0 = (a_y0 > b_y0) ? a_y0 : b_y0;
    x1 = (ar < br) ? ar : br;
    y1 = (ab < bb) ? ab : bb;
  end

  always_ff @(posedge clk) begin
    ov_r <= (x1 >= x0) && (y1 >= y0);
    iw_r <= x1 - x0;
    ih_r <= y1 - y0;
    aw_r <= ar - a_x0;
    ah_r <= ab - a_y0;
    bw_r <= br - b_x0;
    bh_r <= bb - b_y0;
  end

  always_comb begin
    ia = ov_r ? iw_r * ih_r : '0;
    aa = aw_r * ah_r;
    ba = bw_r * bh_r;
    u  = {2'b0, aa} + {2'b0, ba} - {2'b0, ia};
  end

  always_ff @(posedge clk) begin
    if (u == '0) begin
      inter <= '0;
      uni   <= {{(2*W+1){1'b0}}, 1'b1};
    end else begin
      inter <= ia;
      uni   <= u;
    end
  end
endmodule

### rtl/igbt_cmp_unit.sv
// igbt_cmp_unit: shared cross-multiply compare, a*b > c*d, registered products
// depends on igbt_pkg
`timescale 1ns / 1ps
module igbt_cmp_unit import igbt_pkg::*; #(
  parameter int AW = 26,
  parameter int BW = 26
) (
  input  logic          clk,
  input  logic [AW-1:0] a, c,
  input  logic [BW-1:0] b, d,
  output logic          gt
);
  logic [AW+BW-1:0] p1_r, p2_r;
  always_ff @(posedge clk) begin
    p1_r <= a * b;
    p2_r <= c * d;
  end
  assign gt = p1_r > p2_r;
endmodule

### rtl/iou_greedy_box_tracker_top.sv
// iou_greedy_box_tracker_top: detection buffer, track table and matching sequencer
// depends on igbt_pkg, igbt_iou_unit, igbt_cmp_unit
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_valid / in_stall | cmd, x_min, y_min, x_max, y_max
//  out_    | out | out_valid/out_stall | track_valid, tid, box, counts, last
//  cfg_    | in  | cfg_we              | cfg_idx, cfg_data
//
// detection beats are stored while idle (dropped if full); the block stays ready.
// an end-of-frame beat holds in_stall until its last result beat has left:
//   id ordering: one scan of every slot per pass, one pass per active track plus one
//   matching, per track: a setup step, then each free detection goes through the
//   single iou and compare units, a detection already taken is skipped, the scan
//   closes and the threshold check follows when a best detection exists;
//   matching is left from the setup step once every track is done
//   new tracks: one pass over the detections; miss update: one pass over active tracks
//   results: the first beat is loaded, then one beat per unstalled cycle,
//   and the block returns to idle as the last beat is taken
// reset is synchronous; tables need no clearing, only slot valid bits.
// out_stall just holds the current beat.
`timescale 1ns / 1ps
module iou_greedy_box_tracker_top import igbt_pkg::*; #(
  parameter int MAX_TRACKS     = MaxTracks,
  parameter int MAX_DETECTIONS = MaxDetections,
  parameter int COORD_BITS     = CoordBits
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [COORD_BITS-1:0] in_x_min,
  input  logic [COORD_BITS-1:0] in_y_min,
  input  logic [COORD_BITS-1:0] in_x_max,
  input  logic [COORD_BITS-1:0] in_y_max,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_track_valid,
  output logic [IdBits-1:0]     out_tid,
  output logic [COORD_BITS-1:0] out_box_left,
  output logic [COORD_BITS-1:0] out_box_top,
  output logic [COORD_BITS-1:0] out_box_right,
  output logic [COORD_BITS-1:0] out_box_bottom,
  output logic [CntBits-1:0]    out_hit_count,
  output logic [CntBits-1:0]    out_miss_count,
  output logic                  out_is_confirmed,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_idx,
  input  logic [ThrBits-1:0]    cfg_data
);
  localparam int W   = COORD_BITS;
  localparam int TB  = $clog2(MAX_TRACKS);
  localparam int DB  = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int DCB = $clog2(MAX_DETECTIONS + 1);
  localparam int LB  = $clog2(MAX_TRACKS + 1);
  localparam int IW  = 2*W;
  localparam int UW  = 2*W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_ORD, S_ORD_END, S_MSTART, S_MPAIR, S_MW1, S_MW2, S_MW3,
    S_MDONE, S_NEW, S_OLD, S_EMIT
  } state_t;
  state_t state_r;

  // config
  logic [CntBits-1:0] miss_limit_r, confirm_hits_r;
  logic [ThrBits-1:0] min_iou_r;

  // stores
  logic [W-1:0]  det_x0 [MAX_DETECTIONS], det_y0 [MAX_DETECTIONS];
  logic [W-1:0]  det_x1 [MAX_DETECTIONS], det_y1 [MAX_DETECTIONS];
  logic [DCB-1:0] det_count_r;
  logic [MAX_TRACKS-1:0] used_r, taken_r, matched_r;
  logic [MAX_DETECTIONS-1:0] col_used_r, det_matched_r;
  logic [IdBits-1:0] slot_id [MAX_TRACKS];
  logic [W-1:0] sb_x0 [MAX_TRACKS], sb_y0 [MAX_TRACKS];
  logic [W-1:0] sb_x1 [MAX_TRACKS], sb_y1 [MAX_TRACKS];
  logic [CntBits-1:0] slot_hits [MAX_TRACKS], slot_miss [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] slot_conf;
  logic [IdBits-1:0] next_id_r;

  logic [TB-1:0] ord_r [MAX_TRACKS];
  logic [TB-1:0] list_r [MAX_TRACKS];
  logic [LB-1:0] nt_r, nl_r, k_r;
  logic [TB-1:0] s_r, pick_r;
  logic          pick_ok_r;
  logic [DCB-1:0] j_r;
  logic [DB-1:0]  best_r;
  logic           best_ok_r;
  logic [IW-1:0]  bi_r;
  logic [UW-1:0]  bu_r;

  // shared units
  logic [TB-1:0] cur_s;
  logic [DB-1:0] cur_j;
  logic [IW-1:0] ii;
  logic [UW-1:0] uu;
  logic          gt;
  logic [IW-1:0] ca;
  logic [UW-1:0] cb, cd;
  logic [IW-1:0] cc;
  logic          thr_mode_r;

  assign cur_s = ord_r[k_r[TB-1:0]];
  assign cur_j = j_r[DB-1:0];

  igbt_iou_unit #(.COORD_BITS(W)) u_iou (
    .clk(clk),
    .a_x0(sb_x0[cur_s]), .a_y0(sb_y0[cur_s]), .a_x1(sb_x1[cur_s]), .a_y1(sb_y1[cur_s]),
    .b_x0(det_x0[cur_j]), .b_y0(det_y0[cur_j]), .b_x1(det_x1[cur_j]), .b_y1(det_y1[cur_j]),
    .inter(ii), .uni(uu)
  );

  // thr mode: bi*65536 > min_iou*bu, else ii*bu > bi*uu
  always_comb begin
    if (thr_mode_r) begin
      ca = bi_r;
      cb = UW'(65536);
      cc = IW'(min_iou_r);
      cd = bu_r;
    end else begin
      ca = ii;
      cb = bu_r;
      cc = bi_r;
      cd = uu;
    end
  end

  igbt_cmp_unit #(.AW(IW), .BW(UW)) u_cmp (
    .clk(clk), .a(ca), .b(cb), .c(cc), .d(cd), .gt(gt)
  );

  // lowest free slot, a small priority encoder
  logic [TB-1:0] free_slot;
  logic          free_ok;
  always_comb begin
    free_slot = '0;
    free_ok   = 1'b0;
    for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_slot = TB'(i);
        free_ok   = 1'b1;
      end
    end
  end

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  logic [CntBits-1:0] hits_inc, miss_inc;
  assign hits_inc = (slot_hits[cur_s] == '1) ? slot_hits[cur_s] : slot_hits[cur_s] + 1'b1;
  assign miss_inc = (slot_miss[cur_s] == '1) ? slot_miss[cur_s] : slot_miss[cur_s] + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      miss_limit_r   <= MissLimitReset;
      confirm_hits_r <= ConfirmHitsReset;
      min_iou_r      <= MinIouReset;
      det_count_r    <= '0;
      used_r         <= '0;
      next_id_r      <= '0;
      out_valid      <= 1'b0;
      thr_mode_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MISS_LIMIT:   miss_limit_r   <= cfg_data[CntBits-1:0];
          CFG_CONFIRM_HITS: confirm_hits_r <= cfg_data[CntBits-1:0];
          CFG_MIN_IOU:      min_iou_r      <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_cmd == CMD_DET) begin
              if (det_count_r < DCB'(MAX_DETECTIONS)) begin
                det_x0[det_count_r[DB-1:0]] <= in_x_min;
                det_y0[det_count_r[DB-1:0]] <= in_y_min;
                det_x1[det_count_r[DB-1:0]] <= in_x_max;
                det_y1[det_count_r[DB-1:0]] <= in_y_max;
                det_count_r <= det_count_r + 1'b1;
              end
            end else begin
              taken_r       <= '0;
              matched_r     <= '0;
              col_used_r    <= '0;
              det_matched_r <= '0;
              nt_r      <= '0;
              nl_r      <= '0;
              s_r       <= '0;
              pick_ok_r <= 1'b0;
              state_r   <= S_ORD;
            end
          end
        end
        // one slot per cycle, find smallest untaken id
        S_ORD: begin
          if (used_r[s_r] && !taken_r[s_r] &&
              (!pick_ok_r || slot_id[s_r] < slot_id[pick_r])) begin
            pick_r    <= s_r;
            pick_ok_r <= 1'b1;
          end
          if (s_r == TB'(MAX_TRACKS - 1)) state_r <= S_ORD_END;
          else s_r <= s_r + 1'b1;
        end
        S_ORD_END: begin
          if (pick_ok_r) begin
            taken_r[pick_r] <= 1'b1;
            ord_r[nt_r[TB-1:0]] <= pick_r;
            nt_r      <= nt_r + 1'b1;
            pick_ok_r <= 1'b0;
            s_r       <= '0;
            state_r   <= S_ORD;
          end else begin
            k_r     <= '0;
            state_r <= S_MSTART;
          end
        end
        S_MSTART: begin
          j_r        <= '0;
          best_ok_r  <= 1'b0;
          bi_r       <= '0;
          bu_r       <= UW'(1);
          thr_mode_r <= 1'b0;
          state_r <= (k_r == nt_r) ? S_NEW : S_MPAIR;
        end
        // launch pair (cur_s, j) into iou unit
        S_MPAIR: begin
          if (j_r == det_count_r) state_r <= S_MDONE;
          else if (col_used_r[cur_j]) j_r <= j_r + 1'b1;
          else state_r <= S_MW1;
        end
        S_MW1: state_r <= S_MW2;
        S_MW2: state_r <= S_MW3;
        S_MW3: begin
          if (!best_ok_r || gt) begin
            best_ok_r <= 1'b1;
            best_r    <= cur_j;
            bi_r      <= ii;
            bu_r      <= uu;
          end
          j_r     <= j_r + 1'b1;
          state_r <= S_MPAIR;
        end
        // threshold check uses the compare unit in thr mode
        S_MDONE: begin
          if (!best_ok_r) begin
            k_r     <= k_r + 1'b1;
            state_r <= S_MSTART;
          end else if (!thr_mode_r) begin
            thr_mode_r <= 1'b1;
          end else if (j_r != '0) begin
            j_r <= '0; // wait for the product register
          end else begin
            col_used_r[best_r] <= 1'b1;
            if (gt) begin
              sb_x0[cur_s] <= det_x0[best_r];
              sb_y0[cur_s] <= det_y0[best_r];
              sb_x1[cur_s] <= det_x1[best_r];
              sb_y1[cur_s] <= det_y1[best_r];
              slot_hits[cur_s] <= hits_inc;
              slot_miss[cur_s] <= '0;
              if (hits_inc >= confirm_hits_r) slot_conf[cur_s] <= 1'b1;
              matched_r[cur_s] <= 1'b1;
              det_matched_r[best_r] <= 1'b1;
              list_r[nl_r[TB-1:0]] <= cur_s;
              nl_r <= nl_r + 1'b1;
            end
            k_r     <= k_r + 1'b1;
            state_r <= S_MSTART;
          end
        end
        // one detection per cycle
        S_NEW: begin
          if (j_r == det_count_r) begin
            k_r     <= '0;
            state_r <= S_OLD;
          end else begin
            if (!det_matched_r[cur_j] && free_ok) begin
              used_r[free_slot]    <= 1'b1;
              slot_id[free_slot]   <= next_id_r;
              next_id_r            <= next_id_r + 1'b1;
              sb_x0[free_slot]     <= det_x0[cur_j];
              sb_y0[free_slot]     <= det_y0[cur_j];
              sb_x1[free_slot]     <= det_x1[cur_j];
              sb_y1[free_slot]     <= det_y1[cur_j];
              slot_hits[free_slot] <= CntBits'(1);
              slot_miss[free_slot] <= '0;
              slot_conf[free_slot] <= 1'b0;
              list_r[nl_r[TB-1:0]] <= free_slot;
              nl_r <= nl_r + 1'b1;
            end
            j_r <= j_r + 1'b1;
          end
        end
        S_OLD: begin
          if (k_r == nt_r) begin
            k_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            if (!matched_r[cur_s]) begin
              slot_miss[cur_s] <= miss_inc;
              if (miss_inc > miss_limit_r) used_r[cur_s] <= 1'b0;
              else begin
                list_r[nl_r[TB-1:0]] <= cur_s;
                nl_r <= nl_r + 1'b1;
              end
            end
            k_r <= k_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_acc) begin
            if (out_valid && out_last) begin
              out_valid   <= 1'b0;
              det_count_r <= '0;
              state_r     <= S_IDLE;
            end else begin
              out_valid <= 1'b1;
              if (nl_r == '0) begin
                out_track_valid  <= 1'b0;
                out_tid          <= '0;
                out_box_left     <= '0;
                out_box_top      <= '0;
                out_box_right    <= '0;
                out_box_bottom   <= '0;
                out_hit_count    <= '0;
                out_miss_count   <= '0;
                out_is_confirmed <= 1'b0;
                out_last         <= 1'b1;
              end else begin
                out_track_valid  <= 1'b1;
                out_tid          <= slot_id[list_r[k_r[TB-1:0]]];
                out_box_left     <= sb_x0[list_r[k_r[TB-1:0]]];
                out_box_top      <= sb_y0[list_r[k_r[TB-1:0]]];
                out_box_right    <= sb_x1[list_r[k_r[TB-1:0]]];
                out_box_bottom   <= sb_y1[list_r[k_r[TB-1:0]]];
                out_hit_count    <= slot_hits[list_r[k_r[TB-1:0]]];
                out_miss_count   <= slot_miss[list_r[k_r[TB-1:0]]];
                out_is_confirmed <= slot_conf[list_r[k_r[TB-1:0]]];
                out_last         <= (k_r + 1'b1 == nl_r);
                k_r <= k_r + 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // threshold pass: j_r is still nonzero on entry, which lets the wait for the product register pass
  // (j_r equals det_count at entry; when det_count is zero no best exists)

  // results only leave while emitting
  a_out_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_EMIT) else $error("result outside emit");
  // no input taken while busy
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("input taken while busy");
  // detection count bounded
  a_det_bound: assert property (@(posedge clk) disable iff (!rst_n)
    det_count_r <= DCB'(MAX_DETECTIONS)) else $error("detection overflow");
endmodule

### dv/iou_greedy_box_tracker_top_test.sv
// iou_greedy_box_tracker_top_test: self-checking bench for the greedy iou box tracker
// depends on igbt_pkg and iou_greedy_box_tracker_top; predicts track lists per frame
`timescale 1ns / 1ps
module iou_greedy_box_tracker_top_test;
  import igbt_pkg::*;

  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic        cmd;
    logic [11:0] x0;
    logic [11:0] y0;
    logic [11:0] x1;
    logic [11:0] y1;
  } box_beat_t;

  typedef struct packed {
    logic        tvalid;
    logic [15:0] id;
    logic [11:0] l;
    logic [11:0] t;
    logic [11:0] r;
    logic [11:0] b;
    logic [7:0]  hits;
    logic [7:0]  misses;
    logic        conf;
    logic        last;
  } track_beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_cmd;
  logic [11:0]           in_x_min, in_y_min, in_x_max, in_y_max;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_track_valid;
  logic [15:0]           out_tid;
  logic [11:0]           out_box_left, out_box_top, out_box_right, out_box_bottom;
  logic [7:0]            out_hit_count, out_miss_count;
  logic                  out_is_confirmed;
  logic                  out_last;
  logic                  cfg_we;
  logic [CfgIdxBits-1:0] cfg_idx;
  logic [ThrBits-1:0]    cfg_data;

  iou_greedy_box_tracker_top DUT (.*);

  // predictor state: detection buffer and track table
  logic [11:0] pend_box [MaxDetections][4];
  int          pend_cnt;
  logic        trk_used [MaxTracks];
  logic [15:0] trk_id   [MaxTracks];
  logic [11:0] trk_box  [MaxTracks][4];
  logic [7:0]  trk_hits [MaxTracks];
  logic [7:0]  trk_miss [MaxTracks];
  logic        trk_conf [MaxTracks];
  logic [15:0] id_next;
  logic [7:0]  lim_miss, lim_conf;
  logic [15:0] lim_iou;

  box_beat_t   pending_beats[$];
  track_beat_t expected_tracks[$];
  int          fail_cnt;
  int          idle_cycles;
  bit          hold_req;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_cnt++;
  endtask

  // intersection and union, inverted edges clamped to the min edge
  function automatic void overlap(input logic [11:0] a[4], input logic [11:0] b[4],
                                  output longint unsigned in_a, output longint unsigned un);
    longint unsigned ar, ab, br, bb, x0, y0, x1, y1, aa, ba;
    ar = (a[2] > a[0]) ? a[2] : a[0];
    ab = (a[3] > a[1]) ? a[3] : a[1];
    br = (b[2] > b[0]) ? b[2] : b[0];
    bb = (b[3] > b[1]) ? b[3] : b[1];
    x0 = (a[0] > b[0]) ? a[0] : b[0];
    y0 = (a[1] > b[1]) ? a[1] : b[1];
    x1 = (ar < br) ? ar : br;
    y1 = (ab < bb) ? ab : bb;
    in_a = (x1 >= x0 && y1 >= y0) ? (x1 - x0) * (y1 - y0) : 0;
    aa = (ar - a[0]) * (ab - a[1]);
    ba = (br - b[0]) * (bb - b[1]);
    un = aa + ba - in_a;
    if (un == 0) begin
      in_a = 0;
      un = 1;
    end
  endfunction

  function automatic track_beat_t track_entry(input int s, input bit is_last);
    track_beat_t e;
    e = '{1'b1, trk_id[s], trk_box[s][0], trk_box[s][1], trk_box[s][2], trk_box[s][3],
          trk_hits[s], trk_miss[s], trk_conf[s], is_last};
    return e;
  endfunction

  // association at end of frame, queues the expected track list
  task automatic predict_frame();
    int   ord[$];
    int   list[$];
    bit   taken[MaxTracks], matched[MaxTracks];
    bit   col_used[MaxDetections], det_hit[MaxDetections];
    int   pick, best, s, j;
    longint unsigned bi, bu, ii, uu;
    logic [11:0] tb[4], db[4];
    track_beat_t empty_beat;
    taken = '{default: 0};
    matched = '{default: 0};
    col_used = '{default: 0};
    det_hit = '{default: 0};
    forever begin
      pick = -1;
      for (s = 0; s < MaxTracks; s++)
        if (trk_used[s] && !taken[s] && (pick < 0 || trk_id[s] < trk_id[pick])) pick = s;
      if (pick < 0) break;
      taken[pick] = 1;
      ord.insert(ord.size(), pick);
    end
    foreach (ord[k]) begin
      s = ord[k];
      best = -1;
      bi = 0;
      bu = 1;
      tb = trk_box[s];
      for (j = 0; j < pend_cnt; j++) begin
        if (col_used[j]) continue;
        db = pend_box[j];
        overlap(tb, db, ii, uu);
        // products stay below 2^49, no overflow in 128-bit compare
        if (best < 0 || ({64'd0, ii} * bu) > ({64'd0, bi} * uu)) begin
          best = j;
          bi = ii;
          bu = uu;
        end
      end
      if (best < 0) continue;
      col_used[best] = 1;
      if ({64'd0, bi} << 16 > {64'd0, longint'(lim_iou)} * bu) begin
        trk_box[s] = pend_box[best];
        if (trk_hits[s] != 8'hff) trk_hits[s]++;
        trk_miss[s] = 0;
        if (trk_hits[s] >= lim_conf) trk_conf[s] = 1;
        matched[s] = 1;
        det_hit[best] = 1;
        list.insert(list.size(), s);
      end
    end
    for (j = 0; j < pend_cnt; j++) begin
      if (det_hit[j]) continue;
      for (s = 0; s < MaxTracks; s++) if (!trk_used[s]) break;
      if (s >= MaxTracks) continue;
      trk_used[s] = 1;
      trk_id[s] = id_next;
      id_next++;
      trk_box[s] = pend_box[j];
      trk_hits[s] = 1;
      trk_miss[s] = 0;
      trk_conf[s] = 0;
      list.insert(list.size(), s);
    end
    foreach (ord[k]) begin
      s = ord[k];
      if (matched[s]) continue;
      if (trk_miss[s] != 8'hff) trk_miss[s]++;
      if (trk_miss[s] > lim_miss) trk_used[s] = 0;
      else list.insert(list.size(), s);
    end
    if (list.size() == 0) begin
      empty_beat = '{last: 1'b1, default: '0};
      expected_tracks.insert(expected_tracks.size(), empty_beat);
    end else begin
      foreach (list[k])
        expected_tracks.insert(expected_tracks.size(),
                               track_entry(list[k], k == list.size() - 1));
    end
    pend_cnt = 0;
  endtask

  task automatic predict_beat(input box_beat_t bt);
    if (bt.cmd == CMD_EOF) predict_frame();
    else if (pend_cnt < MaxDetections) begin
      pend_box[pend_cnt] = '{bt.x0, bt.y0, bt.x1, bt.y1};
      pend_cnt++;
    end
  endtask

  // sampled handshake state at the rising edge
  logic in_stall_q;
  always @(posedge clk) begin
    in_stall_q <= in_stall;
    if (rst_n && in_valid && !in_stall)
      predict_beat('{in_cmd, in_x_min, in_y_min, in_x_max, in_y_max});
  end

  // driver: one beat at a time from the queue, random gap before each
  int gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      {in_cmd, in_x_min, in_y_min, in_x_max, in_y_max} <= '0;
      gap_left <= 0;
    end else if (in_valid && !in_stall_q) begin
      // beat taken on the last rising edge; fall through to the next one
      if (pending_beats.size() > 0 && gap_left == 0) begin
        {in_cmd, in_x_min, in_y_min, in_x_max, in_y_max} <= pending_beats.pop_front();
        gap_left <= $urandom_range(0, 13);
        in_valid <= 1;
      end else in_valid <= 0;
    end else if (!in_valid) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (pending_beats.size() > 0) begin
        {in_cmd, in_x_min, in_y_min, in_x_max, in_y_max} <= pending_beats.pop_front();
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        in_valid <= 1;
      end
    end
  end

  // receiver stall: random per beat, plus one long hold-off when requested
  int stall_left;
  int long_hold;
  bit hold_done;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      stall_left <= 0;
      long_hold <= 0;
      hold_done <= 0;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1;
      long_hold <= 400;
      hold_done <= 1;
    end else if (long_hold > 0) begin
      out_stall <= 1;
      long_hold <= long_hold - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 0;
      if (out_valid && !out_stall)
        stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
    end
  end

  // monitor
  always @(posedge clk) begin
    track_beat_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_track_valid, out_tid, out_box_left, out_box_top, out_box_right,
              out_box_bottom, out_hit_count, out_miss_count, out_is_confirmed, out_last};
      if (expected_tracks.size() == 0)
        report_mismatch("unexpected beat", 64'(got.id), 64'd0);
      else begin
        want = expected_tracks.pop_front();
        if (got.tvalid !== want.tvalid)
          report_mismatch("track_valid", 64'(got.tvalid), 64'(want.tvalid));
        if (got.id !== want.id) report_mismatch("tid", 64'(got.id), 64'(want.id));
        if (got.l !== want.l) report_mismatch("box_left", 64'(got.l), 64'(want.l));
        if (got.t !== want.t) report_mismatch("box_top", 64'(got.t), 64'(want.t));
        if (got.r !== want.r) report_mismatch("box_right", 64'(got.r), 64'(want.r));
        if (got.b !== want.b) report_mismatch("box_bottom", 64'(got.b), 64'(want.b));
        if (got.hits !== want.hits)
          report_mismatch("hit_count", 64'(got.hits), 64'(want.hits));
        if (got.misses !== want.misses)
          report_mismatch("miss_count", 64'(got.misses), 64'(want.misses));
        if (got.conf !== want.conf)
          report_mismatch("is_confirmed", 64'(got.conf), 64'(want.conf));
        if (got.last !== want.last)
          report_mismatch("last", 64'(got.last), 64'(want.last));
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus helpers
  task automatic push_det(input int a, b, c, d);
    box_beat_t bt;
    bt = '{CMD_DET, 12'(a), 12'(b), 12'(c), 12'(d)};
    pending_beats.insert(pending_beats.size(), bt);
  endtask

  task automatic push_eof();
    box_beat_t bt;
    bt = '{CMD_EOF, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom)};
    pending_beats.insert(pending_beats.size(), bt);
  endtask

  // box near a center, mostly well formed, occasionally inverted
  task automatic push_near(input int cx, input int cy, input int jit);
    int w, h, x, y;
    w = $urandom_range(1, 300);
    h = $urandom_range(1, 300);
    x = cx + $urandom_range(0, 2 * jit) - jit;
    y = cy + $urandom_range(0, 2 * jit) - jit;
    if (x < 0) x = 0;
    if (y < 0) y = 0;
    if (x + w > 4095) x = 4095 - w;
    if (y + h > 4095) y = 4095 - h;
    if ($urandom_range(0, 15) == 0) push_det(x + w, y, x, y + h);
    else push_det(x, y, x + w, y + h);
  endtask

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_valid || expected_tracks.size() > 0)
      @(posedge clk);
    // a detection beat can still be settling inside the block
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= 16'(val);
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_MISS_LIMIT:   lim_miss = 8'(val);
      CFG_CONFIRM_HITS: lim_conf = 8'(val);
      CFG_MIN_IOU:      lim_iou = 16'(val);
      default: ;
    endcase
  endtask

  // several frames of moving objects with random noise boxes
  task automatic run_scene(input int n_beats);
    int cx[6], cy[6], n_obj, cnt, k;
    n_obj = $urandom_range(1, 6);
    foreach (cx[k]) begin
      cx[k] = $urandom_range(0, 4095);
      cy[k] = $urandom_range(0, 4095);
    end
    cnt = 0;
    while (cnt < n_beats) begin
      for (k = 0; k < n_obj; k++) begin
        if ($urandom_range(0, 7) != 0) begin
          push_near(cx[k], cy[k], 20);
          cnt++;
        end
        cx[k] = cx[k] + $urandom_range(0, 20) - 10;
        cy[k] = cy[k] + $urandom_range(0, 20) - 10;
      end
      if ($urandom_range(0, 3) == 0) begin
        push_det($urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 4095));
        cnt++;
      end
      push_eof();
      cnt++;
    end
  endtask

  initial begin
    int k;
    rst_n = 0;
    cfg_we = 0;
    cfg_idx = CFG_MISS_LIMIT;
    cfg_data = 0;
    fail_cnt = 0;
    hold_req = 0;
    pend_cnt = 0;
    id_next = 0;
    trk_used = '{default: 0};
    lim_miss = MissLimitReset;
    lim_conf = ConfirmHitsReset;
    lim_iou = MinIouReset;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: empty frame, extremes, inverted and zero-area boxes
    push_eof();
    push_det(0, 0, 4095, 4095);
    push_det(4095, 4095, 0, 0);
    push_det(100, 100, 100, 100);
    push_det(10, 10, 60, 60);
    push_eof();
    push_det(0, 0, 4095, 4095);
    push_det(12, 12, 62, 62);
    push_det(2000, 2000, 2100, 2100);
    push_eof();
    push_eof();
    wait_drained();

    // any match confirms, tracks die on first miss, zero threshold
    write_reg(CFG_CONFIRM_HITS, 0);
    write_reg(CFG_MISS_LIMIT, 0);
    write_reg(CFG_MIN_IOU, 0);
    for (k = 0; k < 18; k++) push_det(k * 200, k * 100, k * 200 + 150, k * 100 + 90);
    push_eof();
    push_det(5, 5, 40, 40);
    push_eof();
    wait_drained();

    // immortal tracks, strictest threshold; table fills, detections dropped
    write_reg(CFG_MISS_LIMIT, 255);
    write_reg(CFG_CONFIRM_HITS, 255);
    write_reg(CFG_MIN_IOU, 65535);
    run_scene(40);
    // long receiver hold-off while the sender keeps offering beats
    hold_req = 1;
    run_scene(40);
    wait_drained();

    // default-like settings, tracks should persist and confirm
    write_reg(CFG_MISS_LIMIT, 3);
    write_reg(CFG_CONFIRM_HITS, 2);
    write_reg(CFG_MIN_IOU, 19661);
    run_scene(90);
    wait_drained();

    write_reg(CFG_MISS_LIMIT, $urandom_range(0, 255));
    write_reg(CFG_CONFIRM_HITS, $urandom_range(1, 255));
    write_reg(CFG_MIN_IOU, $urandom_range(0, 40000));
    run_scene(100);
    wait_drained();

    repeat (100) @(posedge clk);
    if (fail_cnt == 0 && expected_tracks.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
